// ===== src/column_gap_char_segmenter_defines.svh =====
// assertion macros for the column gap segmenter, clocked on clk with arst_n
`ifndef COLUMN_GAP_CHAR_SEGMENTER_DEFINES_SVH
`define COLUMN_GAP_CHAR_SEGMENTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CGCS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define CGCS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CGCS_ASSERT(name, prop, msg)
`define CGCS_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== src/cgcs_pkg.sv =====
`default_nettype none
package cgcs_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int COL_W = 11;
	localparam int SUM_W = 20;
	localparam int CFG_W = 5;
	localparam int IDX_W = 6;
	localparam logic [CFG_W-1:0] MAX_GAP_RESET = 5'd17;
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic             gap;
		logic [SUM_W-1:0] gap_sum;
		logic [COL_W-1:0] gap_cnt;
		logic [IDX_W-1:0] gap_idx;
		logic             gap_ovf;
		logic             fin;
		logic [IDX_W-1:0] fin_idx;
		logic [COL_W-1:0] fin_pos;
		logic             fin_ovf;
	} event_t;

endpackage
`default_nettype wire

// ===== src/cgcs_divider.sv =====
`default_nettype none
module cgcs_divider (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [cgcs_pkg::SUM_W-1:0] dividend,
	input  wire logic [cgcs_pkg::COL_W-1:0] divisor,
	output logic                           busy,
	output logic                           done,
	output logic [cgcs_pkg::COL_W-1:0]     quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [cgcs_pkg::STEP_W-1:0]   step_q;
	logic [cgcs_pkg::SUM_W-1:0]    dvd_q;
	logic [cgcs_pkg::COL_W-1:0]    dvs_q;
	logic [cgcs_pkg::COL_W-1:0]    rem_q;
	logic                          zero_q;

	logic [cgcs_pkg::COL_W:0]      rem_sh;
	logic [cgcs_pkg::COL_W:0]      dvs_ext;
	logic                          ge;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh  = {rem_q, dvd_q[cgcs_pkg::SUM_W-1]};
		dvs_ext = {1'b0, dvs_q};
		ge      = rem_sh >= dvs_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == cgcs_pkg::STEP_W'(cgcs_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			zero_q <= divisor == '0;
		end else if (busy_q) begin
			rem_q <= ge ? cgcs_pkg::COL_W'(rem_sh - dvs_ext) : rem_sh[cgcs_pkg::COL_W-1:0];
			dvd_q <= {dvd_q[cgcs_pkg::SUM_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = zero_q ? '0 : dvd_q[cgcs_pkg::COL_W-1:0];

endmodule
`default_nettype wire

// ===== src/cgcs_column_track.sv =====
`default_nettype none
module cgcs_column_track (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic                      ink,
	input  wire logic                      column_end,
	input  wire logic                      image_end,
	input  wire logic [cgcs_pkg::CFG_W-1:0] max_gap,
	output cgcs_pkg::event_t               ev
);

	logic                          has_ink_q;
	logic [1:0]                    hist_q;
	logic [cgcs_pkg::COL_W-1:0]    count_q;
	logic [cgcs_pkg::SUM_W-1:0]    sum_q;
	logic [cgcs_pkg::COL_W-1:0]    run_q;
	logic [cgcs_pkg::CFG_W-1:0]    bcount_q;
	logic                          ovf_q;

	logic                          col_done;
	logic                          in_range;
	logic                          empty;
	logic                          process;
	logic                          close;
	logic                          emit;
	logic [cgcs_pkg::SUM_W-1:0]    sum_add;
	logic [cgcs_pkg::COL_W-1:0]    run_add;
	logic [cgcs_pkg::CFG_W-1:0]    bcount_nx;
	logic                          ovf_nx;
	logic [cgcs_pkg::COL_W-1:0]    count_nx;

	always_comb begin
		col_done  = column_end | image_end;
		in_range  = count_q < cgcs_pkg::COL_W'(cgcs_pkg::MAX_COLUMNS);
		empty     = !(has_ink_q | ink);
		process   = col_done & in_range;
		// gap closes: two columns back empty, last one and this one inked
		close     = process & hist_q[1] & !hist_q[0] & !empty;
		emit      = close & (bcount_q < max_gap);
		sum_add   = empty ? sum_q + cgcs_pkg::SUM_W'(count_q) : sum_q;
		run_add   = empty ? run_q + 1'b1 : run_q;
		bcount_nx = emit ? bcount_q + 1'b1 : bcount_q;
		ovf_nx    = ovf_q | (close & !emit);
		count_nx  = process ? count_q + 1'b1 : count_q;

		ev.gap     = emit;
		ev.gap_sum = sum_add;
		ev.gap_cnt = run_add;
		ev.gap_idx = {1'b0, bcount_q} + 1'b1;
		ev.gap_ovf = ovf_q;
		ev.fin     = image_end;
		ev.fin_idx = {1'b0, bcount_nx} + 1'b1;
		ev.fin_pos = count_nx;
		ev.fin_ovf = ovf_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_ink_q <= 1'b0;
			hist_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			run_q     <= '0;
			bcount_q  <= '0;
			ovf_q     <= 1'b0;
		end else if (accept) begin
			if (image_end) begin
				has_ink_q <= 1'b0;
				hist_q    <= '0;
				count_q   <= '0;
				sum_q     <= '0;
				run_q     <= '0;
				bcount_q  <= '0;
				ovf_q     <= 1'b0;
			end else if (col_done) begin
				has_ink_q <= 1'b0;
				if (in_range) begin
					hist_q   <= {hist_q[0], empty};
					count_q  <= count_nx;
					sum_q    <= close ? '0 : sum_add;
					run_q    <= close ? '0 : run_add;
					bcount_q <= bcount_nx;
					ovf_q    <= ovf_nx;
				end
			end else begin
				has_ink_q <= has_ink_q | ink;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/column_gap_char_segmenter.sv =====
// results: only an image end or an emitted gap makes an output beat; an image
// end goes through ST_EMIT_FIN. An emitted gap runs the restoring divider,
// 20 steps, then ST_EMIT_GAP; in_ready stays low until the boundary loads
// throughput: one pixel per cycle in ST_IDLE; an image end or an emitted gap
// holds in_ready low, and its beat loads wait on out_ready while one is held
// reset: arst_n clears all column state and the output, register goes to 17
`default_nettype none
`include "column_gap_char_segmenter_defines.svh"
module column_gap_char_segmenter (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [cgcs_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      ink,
	input  wire logic                      column_end,
	input  wire logic                      image_end,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [cgcs_pkg::IDX_W-1:0]     boundary_index,
	output logic [cgcs_pkg::COL_W-1:0]     position,
	output logic                           overflowed,
	output logic                           final_res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT_GAP,
		ST_EMIT_FIN
	} state_t;

	state_t                        state_q;
	logic [cgcs_pkg::CFG_W-1:0]    max_gap_q;
	cgcs_pkg::event_t              ev;
	cgcs_pkg::event_t              pend_q;
	logic                          accept;
	logic                          slot_free;
	logic                          load_out;
	logic                          div_busy;
	logic                          div_done;
	logic [cgcs_pkg::COL_W-1:0]    div_quot;

	logic                          out_valid_q;
	logic [cgcs_pkg::IDX_W-1:0]    idx_q;
	logic [cgcs_pkg::COL_W-1:0]    pos_q;
	logic                          ovf_q;
	logic                          fin_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == ST_IDLE;
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = slot_free && (state_q == ST_EMIT_GAP || state_q == ST_EMIT_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= cgcs_pkg::MAX_GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_gap_q <= cfg_data;
		end
	end

	cgcs_column_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.ink        (ink),
		.column_end (column_end),
		.image_end  (image_end),
		.max_gap    (max_gap_q),
		.ev         (ev)
	);

	cgcs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && ev.gap),
		.dividend (ev.gap_sum),
		.divisor  (ev.gap_cnt),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			fin_q       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (ev.gap) begin
							state_q <= ST_DIV;
						end else if (ev.fin) begin
							state_q <= ST_EMIT_FIN;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT_GAP;
					end
				end
				ST_EMIT_GAP: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						idx_q       <= pend_q.gap_idx;
						pos_q       <= div_quot;
						ovf_q       <= pend_q.gap_ovf;
						fin_q       <= 1'b0;
						state_q     <= pend_q.fin ? ST_EMIT_FIN : ST_IDLE;
					end
				end
				ST_EMIT_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						idx_q       <= pend_q.fin_idx;
						pos_q       <= pend_q.fin_pos;
						ovf_q       <= pend_q.fin_ovf;
						fin_q       <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign boundary_index = idx_q;
	assign position       = pos_q;
	assign overflowed     = ovf_q;
	assign final_res      = fin_q;

	`CGCS_ASSERT(a_ready_not_dividing, !(in_ready && div_busy), "input ready while dividing")
	`CGCS_ASSERT(a_done_in_div, !div_done || state_q == ST_DIV, "divider done outside wait state")
	`CGCS_ASSERT_NEXT(a_gap_starts_div, accept && ev.gap, state_q == ST_DIV && div_busy, "no div start")
	`CGCS_ASSERT(a_index_nonzero, !out_valid || boundary_index != '0, "boundary beat with zero index")

endmodule
`default_nettype wire
